// ===== src/sha_pkg.sv =====
// Shared types, constants and round functions for the streaming SHA-256 core.
package sha_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  // Request from the controller to the compression engine
  typedef struct packed {
    logic start;
  } sha_eng_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sha_eng_sts_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ===== src/sha_engine.sv =====
// Compression engine: schedule memory, working registers and hash words.
module sha_engine import sha_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sha_eng_req_t req,
  input  logic         wr_en,
  input  logic [3:0]   wr_addr,
  input  logic [31:0]  wr_data,
  input  logic         hash_reinit,
  input  logic [2:0]   hash_sel,
  output logic [31:0]  hash_word,
  output sha_eng_sts_t sts
);

  // 16-word rolling message schedule memory, one write and two reads a cycle
  logic [31:0] sched_mem [16];
  logic [31:0] rd_a_r, rd_b_r;

  logic [31:0] h_r [8];
  logic [31:0] va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r;
  logic [31:0] w2_r, w7_r, w16_r;
  logic [6:0]  rnd_r;
  logic        busy_r, done_r;
  logic        prime_r;

  // Short delay line w[t-1] .. w[t-6] feeding w[t-7]
  logic [31:0] wd_r [6];
  logic [31:0] w_hist6;

  logic [5:0]  rnd;
  logic [31:0] w_cur, t1, t2;
  logic [3:0]  ws, rd_a_addr, rd_b_addr;
  logic        sched_we;
  logic [3:0]  sched_wa;
  logic [31:0] sched_wd;

  assign rnd     = rnd_r[5:0];
  assign ws      = rnd_r[3:0];
  assign w_hist6 = wd_r[5];

  // Schedule history: registers hold w[t-2], w[t-7], w[t-16]; read port a
  // supplies w[t-15] (slot t+1, read one round ahead).
  always_comb begin
    if (rnd < 6'd16) begin
      w_cur = rd_b_r;
    end else begin
      w_cur = ssig1(w2_r) + w7_r + ssig0(rd_a_r) + w16_r;
    end
  end

  assign t1 = vh_r + bsig1(ve_r) + ((ve_r & vf_r) ^ (~ve_r & vg_r)) + ROUND_K[rnd] + w_cur;
  assign t2 = bsig0(va_r) + ((va_r & vb_r) ^ (va_r & vc_r) ^ (vb_r & vc_r));

  // Read addresses: a = next w[t-15] slot, b = next message word;
  // the prime cycle fetches word 0
  assign rd_a_addr = (busy_r && !prime_r) ? (ws + 4'd2) : 4'd1;
  assign rd_b_addr = (busy_r && !prime_r) ? (ws + 4'd1) : 4'd0;

  always_comb begin
    sched_we = wr_en;
    sched_wa = wr_addr;
    sched_wd = wr_data;
    if (busy_r && !prime_r) begin
      sched_we = 1'b1;
      sched_wa = ws;
      sched_wd = w_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (sched_we) begin
      sched_mem[sched_wa] <= sched_wd;
    end
    rd_a_r <= (sched_we && sched_wa == rd_a_addr) ? sched_wd : sched_mem[rd_a_addr];
    rd_b_r <= (sched_we && sched_wa == rd_b_addr) ? sched_wd : sched_mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      prime_r <= 1'b0;
      rnd_r   <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else begin
      done_r <= 1'b0;
      if (hash_reinit) begin
        for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
      end
      if (req.start && !busy_r) begin
        // prime step to get the first word out of the memory
        busy_r  <= 1'b1;
        prime_r <= 1'b1;
        rnd_r   <= '0;
        {va_r, vb_r, vc_r, vd_r} <= {h_r[0], h_r[1], h_r[2], h_r[3]};
        {ve_r, vf_r, vg_r, vh_r} <= {h_r[4], h_r[5], h_r[6], h_r[7]};
      end else if (busy_r && prime_r) begin
        prime_r <= 1'b0;
      end else if (busy_r) begin
        va_r <= t1 + t2; vb_r <= va_r; vc_r <= vb_r; vd_r <= vc_r;
        ve_r <= vd_r + t1; vf_r <= ve_r; vg_r <= vf_r; vh_r <= vg_r;
        w16_r <= rd_a_r;
        w7_r  <= w_hist6;
        w2_r  <= wd_r[0];
        rnd_r <= rnd_r + 7'd1;
        if (rnd == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          h_r[0] <= h_r[0] + t1 + t2; h_r[1] <= h_r[1] + va_r;
          h_r[2] <= h_r[2] + vb_r;    h_r[3] <= h_r[3] + vc_r;
          h_r[4] <= h_r[4] + vd_r + t1; h_r[5] <= h_r[5] + ve_r;
          h_r[6] <= h_r[6] + vf_r;    h_r[7] <= h_r[7] + vg_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !prime_r) begin
      wd_r[0] <= w_cur;
      for (int i = 1; i < 6; i++) wd_r[i] <= wd_r[i-1];
    end
  end

  assign hash_word = h_r[hash_sel];
  assign sts.busy  = busy_r | prime_r;
  assign sts.done  = done_r;

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> $past(busy_r)) else $error("done without a running block");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !wr_en) else $error("schedule write during compression");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rnd_r < 7'd64) else $error("round counter overrun");
`endif

endmodule

// ===== src/sha256_stream_hasher_core.sv =====
// Streaming SHA-256 core: byte absorb, padding sequencer and digest output.
// Accepts one byte per item. Absorbed bytes are packed into 32-bit words and
// written into the 16-word schedule memory; every 64th byte starts a
// compression (a prime step, then 64 rounds, one round per cycle), during
// which input is stalled, so no new byte is taken until it is through. A
// finish item runs the padding sequencer one byte per cycle while the engine
// is idle (up to 72 pad bytes plus one or two compressions), then delivers
// eight digest words through an output register, word 0 first.
module sha256_stream_hasher_core import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sha_out_t out_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_LEN  = 5'b00100,
    ST_WAIT = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t       state_r;
  logic [5:0]   fill_r;
  logic [63:0]  bits_r;
  logic [63:0]  len_r;
  logic [23:0]  word_r;
  logic [2:0]   len_idx_r;
  logic [2:0]   out_idx_r;
  logic         out_valid_r;
  sha_out_t     out_r;

  sha_eng_req_t eng_req;
  sha_eng_sts_t eng_sts;
  logic         wr_en;
  logic [31:0]  wr_data;
  logic         hash_reinit;
  logic [31:0]  hash_word;

  logic         push;
  logic [7:0]   push_byte;
  logic         in_acc;

  assign in_stall = (state_r != ST_IDLE) || eng_sts.busy;
  assign in_acc   = in_valid && !in_stall;

  // Byte source: input while idle, padding or length bytes in ST_PAD and ST_LEN
  always_comb begin
    push      = 1'b0;
    push_byte = 8'h00;
    unique case (state_r)
      ST_IDLE: begin
        push      = in_acc;
        push_byte = (in_data.command == CMD_FINISH) ? PAD_BYTE : in_data.data_byte;
      end
      ST_PAD: begin
        push = !eng_sts.busy && (fill_r != LEN_START);
      end
      ST_LEN: begin
        push      = !eng_sts.busy;
        push_byte = len_r[63 - 8*len_idx_r -: 8];
      end
      ST_WAIT, ST_OUT: ;
      default: ;
    endcase
  end

  assign wr_en       = push && (fill_r[1:0] == 2'b11);
  assign wr_data     = {word_r, push_byte};
  assign eng_req     = '{start: push && (fill_r == 6'd63)};

  logic [3:0] wr_addr;
  assign wr_addr = fill_r[5:2];

  logic start_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b0;
    end else begin
      start_r <= eng_req.start;
    end
  end

  assign hash_reinit = (state_r == ST_OUT) && out_valid_r && !out_stall && out_r.last_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bits_r      <= '0;
      len_idx_r   <= '0;
      out_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (push) begin
        fill_r <= fill_r + 6'd1;
        word_r <= {word_r[15:0], push_byte};
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.command == CMD_FINISH) begin
              len_r  <= bits_r;
              state_r <= ST_PAD;
            end else begin
              bits_r <= bits_r + 64'd8;
            end
          end
        end
        ST_PAD: begin
          if (fill_r == LEN_START && !eng_sts.busy) begin
            state_r   <= ST_LEN;
            len_idx_r <= '0;
          end
        end
        ST_LEN: begin
          if (push) begin
            len_idx_r <= len_idx_r + 3'd1;
            if (len_idx_r == 3'd7) state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!eng_sts.busy && !eng_req.start && !start_r) begin
            state_r   <= ST_OUT;
            out_idx_r <= '0;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            if (out_valid_r && out_r.last_word) begin
              out_valid_r <= 1'b0;
              state_r     <= ST_IDLE;
              bits_r      <= '0;
              fill_r      <= '0;
            end else begin
              out_valid_r       <= 1'b1;
              out_r.digest_word <= hash_word;
              out_r.word_index  <= out_idx_r;
              out_r.last_word   <= (out_idx_r == 3'd7);
              out_idx_r         <= out_idx_r + 3'd1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  sha_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (eng_req),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .hash_reinit (hash_reinit),
    .hash_sel    (out_idx_r),
    .hash_word   (hash_word),
    .sts         (eng_sts)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_OUT) else $error("result outside output phase");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    eng_sts.busy |-> in_stall) else $error("input taken during compression");
  a_len_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEN && push && len_idx_r == 3'd0) |-> fill_r == LEN_START)
    else $error("length field misaligned");
`endif

endmodule

// ===== verif/sha256_stream_hasher_checker.sv =====
// Digest predictor and result comparator for the streaming SHA-256 core.
`timescale 1ns / 100ps
module sha256_stream_hasher_checker import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  sha_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  sha_out_t out_data,
  output int       fail_count,
  output int       pending_words
);

  // predictor state
  logic [31:0] chain_h [8];
  logic [7:0]  blk_bytes [64];
  logic [5:0]  blk_fill;
  logic [63:0] bit_total;
  sha_out_t    digest_q [$];

  function automatic logic [31:0] ror32(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // one 64-round compression over the buffered block
  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int r = 0; r < 16; r++)
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + w[r-7] + s0 + w[r-16];
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[r] + w[r];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endtask

  task automatic add_byte(logic [7:0] v);
    blk_bytes[blk_fill] = v;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) compress_blk();
  endtask

  task automatic restart_msg();
    for (int i = 0; i < 8; i++) chain_h[i] = INIT_H[i];
    blk_fill = '0;
    bit_total = '0;
  endtask

  task automatic take_beat(sha_in_t beat);
    logic [63:0] len;
    sha_out_t    w;
    if (beat.command == CMD_ABSORB) begin
      bit_total += 64'd8;
      add_byte(beat.data_byte);
    end else begin
      len = bit_total;
      add_byte(PAD_BYTE);
      while (blk_fill != LEN_START) add_byte(8'h00);
      for (int i = 0; i < 8; i++) add_byte(len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        w.digest_word = chain_h[i];
        w.word_index  = 3'(i);
        w.last_word   = (i == 7);
        digest_q.push_back(w);
      end
      restart_msg();
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    restart_msg();
  end

  assign pending_words = digest_q.size();

  // watch both channels at the rising edge
  always @(posedge clk) begin
    sha_out_t exp_w;
    if (rst_n) begin
      if (in_valid && !in_stall) take_beat(in_data);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          report("unexpected beat", out_data.digest_word, 32'h0);
        end else begin
          exp_w = digest_q.pop_front();
          if (out_data.digest_word !== exp_w.digest_word)
            report("digest_word", out_data.digest_word, exp_w.digest_word);
          if (out_data.word_index !== exp_w.word_index)
            report("word_index", 32'(out_data.word_index), 32'(exp_w.word_index));
          if (out_data.last_word !== exp_w.last_word)
            report("last_word", 32'(out_data.last_word), 32'(exp_w.last_word));
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Stimulus, idling phases and verdict for the streaming SHA-256 core.
`timescale 1ns / 100ps
module testbench import sha_pkg::*;;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sha_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  sha_out_t out_data;
  int       fail_count;
  int       pending_words;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int idle_count;

  sha256_stream_hasher_core u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  sha256_stream_hasher_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending_words
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver: random stall, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // send one beat, with random idle cycles ahead of it; valid stays high
  // on return so that beats can follow back to back
  task automatic send_beat(logic cmd, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, data_byte: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(int len, int fixed_byte);
    for (int i = 0; i < len; i++)
      send_beat(CMD_ABSORB, fixed_byte < 0 ? 8'($urandom_range(255)) : 8'(fixed_byte));
    send_beat(CMD_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  task automatic set_phase(int s_pct, int r_pct);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
  endtask

  initial begin
    int len;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    hold_cycles = 0;
    idle_count = 0;
    set_phase(0, 0);
    rst_n = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty message, byte extremes, lengths around a word boundary
    send_beat(CMD_FINISH, 8'hff);
    send_message(1, 8'h00);
    send_message(1, 8'hff);
    send_message(3, 8'h55);
    send_message(3, 8'haa);
    send_message(4, -1);
    wait_drained();

    // finish right after a full block, and 55/56 byte boundaries
    set_phase(78, 0);
    send_message(64, -1);
    set_phase(0, 78);
    send_message(55, -1);
    set_phase(6, 6);
    send_message(56, -1);
    wait_drained();

    // long receiver hold-off while the sender keeps going
    set_phase(0, 0);
    @(negedge clk);
    hold_cycles = 400;
    send_message(2, -1);
    send_message(0, -1);
    send_message(5, -1);
    // sender pauses until every digest word is out
    wait_drained();

    // random short messages, one per idling phase
    for (int m = 0; m < 4; m++) begin
      case (m % 4)
        0: set_phase(0, 0);
        1: set_phase(78, 0);
        2: set_phase(0, 78);
        default: set_phase(6, 6);
      endcase
      len = $urandom_range(3);
      send_message(len, -1);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sha_pkg.sv
src/sha_engine.sv
src/sha256_stream_hasher_core.sv
verif/sha256_stream_hasher_checker.sv
verif/testbench.sv
